/* sv/aoc_pkg.sv */
// Shared constants and types of the ARGB source-over compositor.
package aoc_pkg;

   // Quotient width of the channel division; one spare top bit keeps six equal stages.
   localparam int NumW = 18;
   localparam int DivSteps = 3;
   localparam int DivStages = NumW / DivSteps;
   localparam int Lanes = 3;

   // floor(x/255) = (x * Recip16) >> 23 for every 16-bit x.
   localparam logic [15:0] Recip16 = 16'h8081;
   localparam int Shift16 = 23;
   // floor(x/255) = (x * Recip24) >> 32 for every 24-bit x.
   localparam logic [24:0] Recip24 = 25'd16843010;
   localparam int Shift24 = 32;

   localparam logic [7:0] AlphaMax = 8'd255;
   localparam logic [7:0] AlphaZero = 8'd0;

   typedef logic [Lanes-1:0][NumW-1:0] lanes_type;

   // Travels beside the division: bypass value or the composite alpha.
   typedef struct packed {
      logic        bypass;
      logic [31:0] pix;
      logic [7:0]  alpha;
   } side_type;

endpackage

/* sv/aoc_if.sv */
// Stream interfaces for the pixel pair input and the composite output.
interface aoc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] background_pixel;
   logic [31:0] foreground_pixel;

   modport source(output valid, output background_pixel, output foreground_pixel,
                  input ready);
   modport sink(input valid, input background_pixel, input foreground_pixel,
                output ready);
endinterface

interface aoc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] blended_pixel;

   modport source(output valid, output blended_pixel, input ready);
   modport sink(input valid, input blended_pixel, output ready);
endinterface

/* sv/argb_over_compositor_unit.sv */
// Source-over compositing of two non-premultiplied 8-bit ARGB pixels.
//
// The req_chan channel carries a background and a foreground pixel; the
// rsp_chan channel returns one blended pixel for every item, in order.
// Both use valid/ready; an item moves when both are high at a clock edge.
//
// The pipeline has nine register stages: three for the alpha and channel
// products and the divisions by 255, then six stages of a restoring divider
// that retires three quotient bits per stage. One item can be accepted in
// every cycle while the output register is not stalled.
//
// The last divider stage is the output register. When it holds an item the
// receiver has not taken, the whole pipeline holds and req_chan.ready drops;
// nothing is lost or repeated. Synchronous reset clears all valid bits.
module argb_over_compositor_unit (
   input logic clock,
   input logic reset,
   aoc_req_if.sink   req_chan,
   aoc_rsp_if.source rsp_chan
);
   import aoc_pkg::*;

   logic en;
   logic div_valid;
   lanes_type div_quo;
   side_type  div_side;

   // Stage 1 registers.
   logic                   v1_ff;
   logic                   byp1_ff;
   logic [31:0]            pix1_ff;
   logic [7:0]             ia1_ff;
   logic [15:0]            p1_ff;
   logic [Lanes-1:0][15:0] bm1_ff;
   logic [Lanes-1:0][15:0] fm1_ff;
   // Stage 2 registers.
   logic                   v2_ff;
   side_type               side2_ff;
   logic [Lanes-1:0][23:0] bt2_ff;
   logic [Lanes-1:0][15:0] fm2_ff;
   // Stage 3 registers.
   logic                   v3_ff;
   side_type               side3_ff;
   lanes_type              num3_ff;

   logic [7:0] fa, ba, nba;
   logic                   byp1_in;
   logic [31:0]            pix1_in;
   logic [15:0]            p1_in;
   logic [Lanes-1:0][15:0] bm1_in, fm1_in;
   side_type               side2_in;
   logic [31:0]            ad_prod;
   logic [7:0]             alpha2;
   logic [Lanes-1:0][23:0] bt2_in;
   lanes_type              num3_in;

   assign en = !div_valid || rsp_chan.ready;
   assign req_chan.ready = en;

   always_comb begin
      fa = req_chan.foreground_pixel[31:24];
      ba = req_chan.background_pixel[31:24];
      nba = AlphaMax - ba;
      byp1_in = (fa == AlphaZero) || (fa == AlphaMax);
      pix1_in = (fa == AlphaZero) ? req_chan.background_pixel : req_chan.foreground_pixel;
      p1_in = 16'(AlphaMax - fa) * 16'(nba);
      for (int l = 0; l < Lanes; l++) begin
         bm1_in[l] = 16'(req_chan.background_pixel[16-8*l +: 8]) * 16'(ba);
         fm1_in[l] = 16'(req_chan.foreground_pixel[16-8*l +: 8]) * 16'(fa);
      end
   end

   always_comb begin
      ad_prod = 32'(p1_ff) * 32'(Recip16);
      alpha2 = AlphaMax - 8'(ad_prod >> Shift16);
      // A zero composite alpha takes the bypass, with an all-zero pixel unless stage 1 already chose a bypass pixel.
      side2_in.bypass = byp1_ff || (alpha2 == AlphaZero);
      side2_in.pix = byp1_ff ? pix1_ff : 32'd0;
      side2_in.alpha = alpha2;
      for (int l = 0; l < Lanes; l++) begin
         bt2_in[l] = 24'(bm1_ff[l]) * 24'(ia1_ff);
      end
   end

   always_comb begin
      logic [48:0] prod;
      for (int l = 0; l < Lanes; l++) begin
         prod = 49'(bt2_ff[l]) * 49'(Recip24);
         num3_in[l] = NumW'(prod >> Shift24) + NumW'(fm2_ff[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_chan.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (en) begin
         byp1_ff <= byp1_in;
         pix1_ff <= pix1_in;
         ia1_ff <= AlphaMax - fa;
         p1_ff <= p1_in;
         bm1_ff <= bm1_in;
         fm1_ff <= fm1_in;
         side2_ff <= side2_in;
         bt2_ff <= bt2_in;
         fm2_ff <= fm1_ff;
         side3_ff <= side2_ff;
         num3_ff <= num3_in;
      end
   end

   aoc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (v3_ff),
      .in_num   (num3_ff),
      .in_side  (side3_ff),
      .out_valid(div_valid),
      .out_quo  (div_quo),
      .out_side (div_side)
   );

   assign rsp_chan.valid = div_valid;
   assign rsp_chan.blended_pixel = div_side.bypass ? div_side.pix :
      {div_side.alpha, div_quo[0][7:0], div_quo[1][7:0], div_quo[2][7:0]};

endmodule

/* sv/aoc_divider.sv */
// Pipelined restoring divider: three lanes share one 8-bit divisor, three bits per stage.
module aoc_divider (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  aoc_pkg::lanes_type  in_num,
   input  aoc_pkg::side_type   in_side,
   output logic                out_valid,
   output aoc_pkg::lanes_type  out_quo,
   output aoc_pkg::side_type   out_side
);
   import aoc_pkg::*;

   for (genvar s = 0; s < DivStages; s++) begin : g_stage
      logic                  valid_ff;
      logic [Lanes-1:0][7:0] rem_ff;
      lanes_type             quo_ff;
      side_type              side_ff;
      logic                  v_src;
      logic [Lanes-1:0][7:0] r_src;
      lanes_type             q_src;
      side_type              sd_src;
      logic [Lanes-1:0][7:0] rem_in;
      lanes_type             quo_in;

      if (s == 0) begin : g_first
         assign v_src = in_valid;
         assign r_src = '0;
         assign q_src = in_num;
         assign sd_src = in_side;
      end else begin : g_next
         assign v_src = g_stage[s-1].valid_ff;
         assign r_src = g_stage[s-1].rem_ff;
         assign q_src = g_stage[s-1].quo_ff;
         assign sd_src = g_stage[s-1].side_ff;
      end

      always_comb begin
         logic [Lanes-1:0][7:0] r_w;
         lanes_type             q_w;
         logic [8:0]            trial;
         r_w = r_src;
         q_w = q_src;
         trial = '0;
         // Numerator bits shift out at the top while quotient bits enter at the bottom.
         for (int l = 0; l < Lanes; l++) begin
            for (int k = 0; k < DivSteps; k++) begin
               trial = {r_w[l], q_w[l][NumW-1]};
               if (trial >= {1'b0, sd_src.alpha}) begin
                  r_w[l] = 8'(trial - {1'b0, sd_src.alpha});
                  q_w[l] = {q_w[l][NumW-2:0], 1'b1};
               end else begin
                  r_w[l] = trial[7:0];
                  q_w[l] = {q_w[l][NumW-2:0], 1'b0};
               end
            end
         end
         rem_in = r_w;
         quo_in = q_w;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (en) begin
            valid_ff <= v_src;
         end
         if (en) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            side_ff <= sd_src;
         end
      end
   end

   assign out_valid = g_stage[DivStages-1].valid_ff;
   assign out_quo = g_stage[DivStages-1].quo_ff;
   assign out_side = g_stage[DivStages-1].side_ff;

endmodule

/* sv/aoc_checker.sv */
// Port-level checks of the compositor, bound to the top level.
module aoc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_blended_pixel
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_blended_pixel))
      else $error("stalled item changed or vanished");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input accepted while the output is stalled");

   a_empty_output_flows: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with an empty output stage");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("item presented right after reset");

endmodule

bind argb_over_compositor_unit aoc_checker u_aoc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_blended_pixel(rsp_chan.blended_pixel)
);
